[src/aece_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aece_pkg
// shared types and constants of the escape parser and cursor engine
// ----------------------------------------------------------------------------
package aece_pkg;

  localparam int MaxArgs   = 16;
  localparam int MaxCols   = 256;
  localparam int MaxRows   = 128;
  localparam int MaxBlanks = 64;

  localparam logic [15:0] ArgLimit = 16'hFFFF;

  localparam logic [7:0] ChBel   = 8'h07;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChEsc   = 8'h1B;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChLbr   = 8'h5B;
  localparam logic [7:0] ChRbr   = 8'h5D;
  localparam logic [7:0] ChQuest = 8'h3F;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChTilde = 8'h7E;
  localparam logic [7:0] FinLo   = 8'h40;
  localparam logic [7:0] FinHi   = 8'h7E;
  localparam logic [7:0] FinIch  = 8'h40;
  localparam logic [7:0] FinCuu  = 8'h41;
  localparam logic [7:0] FinCud  = 8'h42;
  localparam logic [7:0] FinCuf  = 8'h43;
  localparam logic [7:0] FinCub  = 8'h44;
  localparam logic [7:0] FinCnl  = 8'h45;
  localparam logic [7:0] FinCpl  = 8'h46;
  localparam logic [7:0] FinHpr  = 8'h61;
  localparam logic [7:0] FinVpr  = 8'h65;
  localparam logic [7:0] FinSgr  = 8'h6D;

  localparam logic [15:0] SgrFgExt = 16'd38;
  localparam logic [15:0] SgrBgExt = 16'd48;
  localparam logic [15:0] SgrIdx   = 16'd5;
  localparam logic [15:0] SgrRgb   = 16'd2;

  localparam logic [1:0] RegCols = 2'd0;
  localparam logic [1:0] RegRows = 2'd1;
  localparam logic [1:0] RegFg   = 2'd2;
  localparam logic [1:0] RegBg   = 2'd3;

  typedef enum logic [3:0] {
    OP_NOP, OP_CLAMP, OP_LF, OP_DRAW, OP_TAB, OP_CR,
    OP_UP, OP_DOWN, OP_RIGHT, OP_LEFT, OP_NEXT_LINE, OP_PREV_LINE,
    OP_SGR, OP_ARG_CLEAR, OP_ARG_DIGIT, OP_ARG_NEXT
  } dp_op_t;

  typedef struct packed {
    dp_op_t      op;
    logic [7:0]  glyph;
    logic        last;
    logic [3:0]  digit;
    logic [3:0]  sgr_idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic        out_free;
    logic [4:0]  nargs;
    logic [6:0]  ich_count;
    logic [15:0] sgr_code;
  } dp_stat_t;

  typedef struct packed {
    logic [8:0] screen_cols;
    logic [7:0] screen_rows;
    logic [3:0] default_fg;
    logic [3:0] default_bg;
  } cfg_t;

endpackage

[src/ansi_escape_cursor_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_escape_cursor_engine
// terminal byte parser with cursor tracking, colours and attributes
// ----------------------------------------------------------------------------
// decode: a word enters the decode state in the cycle after it is accepted, and
//   waits there while its result would go into a full output register
// input: in_stall holds off a new word until the previous one is through; blank
//   insertion emits up to 64 blanks, attribute sequences walk the stored arguments
// reset: synchronous, clears parser, cursor, attributes and restores
//   the default screen size and colours
module ansi_escape_cursor_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [7:0]  glyph,
  output logic [7:0]  col,
  output logic [6:0]  row,
  output logic [3:0]  fore_colour,
  output logic [3:0]  back_colour,
  output logic [7:0]  attributes,
  output logic        scroll_after,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import aece_pkg::*;

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_cols <= 9'd80;
      cfg.screen_rows <= 8'd24;
      cfg.default_fg  <= 4'd7;
      cfg.default_bg  <= 4'd0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        RegCols: cfg.screen_cols <= pwdata[8:0];
        RegRows: cfg.screen_rows <= pwdata[7:0];
        RegFg:   cfg.default_fg  <= pwdata[3:0];
        RegBg:   cfg.default_bg  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegCols: prdata = {23'd0, cfg.screen_cols};
      RegRows: prdata = {24'd0, cfg.screen_rows};
      RegFg:   prdata = {28'd0, cfg.default_fg};
      RegBg:   prdata = {28'd0, cfg.default_bg};
      default: prdata = 32'd0;
    endcase
  end

  aece_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .stat      (stat),
    .cmd       (cmd)
  );

  aece_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .stat         (stat),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .kind         (kind),
    .glyph        (glyph),
    .col          (col),
    .row          (row),
    .fore_colour  (fore_colour),
    .back_colour  (back_colour),
    .attributes   (attributes),
    .scroll_after (scroll_after),
    .last         (last)
  );

endmodule

[src/aece_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aece_dp
// cursor, colour, argument and output word registers
// ----------------------------------------------------------------------------
module aece_dp (
  input  logic               clk,
  input  logic               rst,
  input  aece_pkg::cfg_t     cfg,
  input  aece_pkg::ctrl_cmd_t cmd,
  output aece_pkg::dp_stat_t stat,
  input  logic               out_stall,
  output logic               out_valid,
  output logic               kind,
  output logic [7:0]         glyph,
  output logic [7:0]         col,
  output logic [6:0]         row,
  output logic [3:0]         fore_colour,
  output logic [3:0]         back_colour,
  output logic [7:0]         attributes,
  output logic               scroll_after,
  output logic               last
);
  import aece_pkg::*;

  logic [7:0]  cursor_col, cursor_col_next;
  logic [6:0]  cursor_row, cursor_row_next;
  logic [3:0]  cur_fg, cur_fg_next;
  logic [3:0]  cur_bg, cur_bg_next;
  logic [7:0]  cur_attr, cur_attr_next;
  logic [15:0] arg_store [MaxArgs];
  logic [15:0] acc;
  logic [4:0]  arg_count;

  logic [8:0]  eff_cols;
  logic [7:0]  eff_rows;
  logic [8:0]  cols_m1;
  logic [7:0]  rows_m1;
  logic [7:0]  lastc;
  logic [6:0]  lastr;
  logic [15:0] cnum;
  logic [19:0] acc_mul;
  logic [15:0] acc_new;
  logic [8:0]  tab_sum;
  logic [16:0] row_sum, col_sum;
  logic        emit, emit_kind, emit_scroll;
  logic [7:0]  emit_glyph, emit_col;
  logic [6:0]  emit_row;
  logic        row_wrap_scroll;
  logic [15:0] code;

  assign eff_cols = (cfg.screen_cols < 9'd4) ? 9'd4 :
                    (cfg.screen_cols > 9'(MaxCols)) ? 9'(MaxCols) : cfg.screen_cols;
  assign eff_rows = (cfg.screen_rows == 8'd0) ? 8'd1 :
                    (cfg.screen_rows > 8'(MaxRows)) ? 8'(MaxRows) : cfg.screen_rows;
  assign cols_m1 = eff_cols - 9'd1;
  assign rows_m1 = eff_rows - 8'd1;
  assign lastc   = cols_m1[7:0];
  assign lastr   = rows_m1[6:0];

  assign cnum    = (arg_store[0] == 16'd0) ? 16'd1 : arg_store[0];
  assign acc_mul = {acc, 3'b000} + {2'b00, acc, 1'b0} + {16'd0, cmd.digit};
  assign acc_new = (acc_mul > {4'd0, ArgLimit}) ? ArgLimit : acc_mul[15:0];
  assign tab_sum = {1'b0, cursor_col} + 9'd4;
  assign row_sum = {10'd0, cursor_row} + {1'b0, cnum};
  assign col_sum = {9'd0, cursor_col} + {1'b0, cnum};
  assign code    = arg_store[cmd.sgr_idx];
  assign row_wrap_scroll = (cursor_row >= lastr);

  assign stat.out_free  = !out_valid || !out_stall;
  assign stat.nargs     = (arg_count < 5'(MaxArgs)) ? arg_count + 5'd1 : 5'(MaxArgs);
  assign stat.ich_count = (cnum > 16'(MaxBlanks)) ? 7'(MaxBlanks) : cnum[6:0];
  assign stat.sgr_code  = code;

  always_comb begin
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    emit        = 1'b0;
    emit_kind   = 1'b0;
    emit_scroll = 1'b0;
    emit_glyph  = 8'd0;
    emit_col    = 8'd0;
    emit_row    = 7'd0;
    case (cmd.op)
      OP_CLAMP: begin
        if (cursor_col > lastc) cursor_col_next = lastc;
        if (cursor_row > lastr) cursor_row_next = lastr;
      end
      OP_LF: begin
        cursor_col_next = 8'd0;
        if (row_wrap_scroll) begin
          cursor_row_next = lastr;
          emit        = 1'b1;
          emit_kind   = 1'b1;
          emit_scroll = 1'b1;
        end else begin
          cursor_row_next = cursor_row + 7'd1;
        end
      end
      OP_DRAW: begin
        emit       = 1'b1;
        emit_glyph = cmd.glyph;
        emit_col   = cursor_col;
        emit_row   = cursor_row;
        if (cursor_col >= lastc) begin
          cursor_col_next = 8'd0;
          if (row_wrap_scroll) begin
            cursor_row_next = lastr;
            emit_scroll     = 1'b1;
          end else begin
            cursor_row_next = cursor_row + 7'd1;
          end
        end else begin
          cursor_col_next = cursor_col + 8'd1;
        end
      end
      OP_TAB: begin
        if (tab_sum >= eff_cols) begin
          cursor_col_next = 8'(tab_sum - eff_cols);
          if (row_wrap_scroll) begin
            cursor_row_next = lastr;
            emit        = 1'b1;
            emit_kind   = 1'b1;
            emit_scroll = 1'b1;
          end else begin
            cursor_row_next = cursor_row + 7'd1;
          end
        end else begin
          cursor_col_next = tab_sum[7:0];
        end
      end
      OP_CR: cursor_col_next = 8'd0;
      OP_UP: cursor_row_next = (cnum >= {9'd0, cursor_row}) ? 7'd0 : cursor_row - cnum[6:0];
      OP_DOWN: cursor_row_next = (row_sum > {10'd0, lastr}) ? lastr : row_sum[6:0];
      OP_RIGHT: cursor_col_next = (col_sum > {9'd0, lastc}) ? lastc : col_sum[7:0];
      OP_LEFT: cursor_col_next = (cnum >= {8'd0, cursor_col}) ? 8'd0 : cursor_col - cnum[7:0];
      OP_NEXT_LINE: begin
        cursor_col_next = 8'd0;
        cursor_row_next = (row_sum > {10'd0, lastr}) ? lastr : row_sum[6:0];
      end
      OP_PREV_LINE: begin
        cursor_col_next = 8'd0;
        cursor_row_next = (cnum >= {9'd0, cursor_row}) ? 7'd0 : cursor_row - cnum[6:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    cur_fg_next   = cur_fg;
    cur_bg_next   = cur_bg;
    cur_attr_next = cur_attr;
    if (cmd.op == OP_SGR) begin
      case (code)
        16'd0: begin
          cur_fg_next   = cfg.default_fg;
          cur_bg_next   = cfg.default_bg;
          cur_attr_next = 8'd0;
        end
        16'd1: cur_attr_next = cur_attr | 8'h01;
        16'd2: cur_attr_next = cur_attr | 8'h02;
        16'd3: cur_attr_next = cur_attr | 8'h04;
        16'd4: cur_attr_next = cur_attr | 8'h08;
        16'd5, 16'd6: cur_attr_next = cur_attr | 8'h10;
        16'd7: cur_attr_next = cur_attr | 8'h20;
        16'd8: cur_attr_next = cur_attr | 8'h40;
        16'd9: cur_attr_next = cur_attr | 8'h80;
        16'd22: cur_attr_next = cur_attr & ~8'h03;
        16'd23: cur_attr_next = cur_attr & ~8'h04;
        16'd24: cur_attr_next = cur_attr & ~8'h08;
        16'd25: cur_attr_next = cur_attr & ~8'h10;
        16'd27: cur_attr_next = cur_attr & ~8'h20;
        16'd28: cur_attr_next = cur_attr & ~8'h40;
        16'd29: cur_attr_next = cur_attr & ~8'h80;
        16'd39: cur_fg_next = cfg.default_fg;
        16'd49: cur_bg_next = cfg.default_bg;
        default: begin
          if (code >= 16'd30 && code <= 16'd37) cur_fg_next = 4'(code - 16'd30);
          else if (code >= 16'd40 && code <= 16'd47) cur_bg_next = 4'(code - 16'd40);
          else if (code >= 16'd90 && code <= 16'd97) cur_fg_next = 4'(code - 16'd82);
          else if (code >= 16'd100 && code <= 16'd107) cur_bg_next = 4'(code - 16'd92);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= 8'd0;
      cursor_row <= 7'd0;
      cur_fg     <= 4'd7;
      cur_bg     <= 4'd0;
      cur_attr   <= 8'd0;
      arg_count  <= 5'd0;
      acc        <= 16'd0;
      out_valid  <= 1'b0;
      for (int i = 0; i < MaxArgs; i++) arg_store[i] <= 16'd0;
    end else begin
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
      cur_fg     <= cur_fg_next;
      cur_bg     <= cur_bg_next;
      cur_attr   <= cur_attr_next;
      case (cmd.op)
        OP_ARG_CLEAR: begin
          arg_count <= 5'd0;
          acc       <= 16'd0;
          for (int i = 0; i < MaxArgs; i++) arg_store[i] <= 16'd0;
        end
        OP_ARG_DIGIT: begin
          if (arg_count < 5'(MaxArgs)) begin
            acc <= acc_new;
            arg_store[arg_count[3:0]] <= acc_new;
          end
        end
        OP_ARG_NEXT: begin
          if (arg_count < 5'(MaxArgs)) begin
            arg_count <= arg_count + 5'd1;
            acc       <= 16'd0;
          end
        end
        default: ;
      endcase
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind         <= emit_kind;
      glyph        <= emit_glyph;
      col          <= emit_col;
      row          <= emit_row;
      fore_colour  <= emit_kind ? 4'd0 : cur_fg;
      back_colour  <= emit_kind ? 4'd0 : cur_bg;
      attributes   <= emit_kind ? 8'd0 : cur_attr;
      scroll_after <= emit_scroll;
      last         <= cmd.last;
    end
  end

endmodule

[src/aece_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aece_ctrl
// escape parser and sequencer for blank insertion and attribute walks
// ----------------------------------------------------------------------------
module aece_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          data_byte,
  input  aece_pkg::dp_stat_t  stat,
  output aece_pkg::ctrl_cmd_t cmd
);
  import aece_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DECODE, S_ICH, S_SGR, S_SGR_EXT} seq_t;
  typedef enum logic [2:0] {P_GROUND, P_ESC, P_CSI_START, P_CSI_ARGS, P_OSC} parse_t;

  seq_t       state, state_next;
  parse_t     parse_state, parse_state_next;
  logic [7:0] byte_q;
  logic [6:0] ich_left, ich_left_next;
  logic [4:0] sgr_i, sgr_i_next;
  logic       is_digit, is_final, needs_out;

  assign is_digit = (byte_q >= ChZero) && (byte_q <= ChNine);
  assign is_final = (byte_q >= FinLo) && (byte_q <= FinHi);
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next       = state;
    parse_state_next = parse_state;
    ich_left_next    = ich_left;
    sgr_i_next       = sgr_i;
    cmd.op           = OP_NOP;
    cmd.glyph        = byte_q;
    cmd.last         = 1'b1;
    cmd.digit        = byte_q[3:0];
    cmd.sgr_idx      = sgr_i[3:0];
    needs_out        = (byte_q == ChLf) ||
                       (parse_state == P_GROUND && (byte_q == ChTab ||
                        (byte_q >= ChSpace && byte_q <= ChTilde)));
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_CLAMP;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!(needs_out && !stat.out_free)) begin
          state_next = S_IDLE;
          if (byte_q == ChLf) begin
            cmd.op           = OP_LF;
            parse_state_next = P_GROUND;
          end else begin
            case (parse_state)
              P_ESC: begin
                if (byte_q == ChLbr) begin
                  cmd.op           = OP_ARG_CLEAR;
                  parse_state_next = P_CSI_START;
                end else if (byte_q == ChRbr) begin
                  parse_state_next = P_OSC;
                end else begin
                  parse_state_next = P_GROUND;
                end
              end
              P_OSC: if (byte_q == ChBel) parse_state_next = P_GROUND;
              P_CSI_START, P_CSI_ARGS: begin
                parse_state_next = P_CSI_ARGS;
                if (parse_state == P_CSI_START && byte_q == ChQuest) begin
                  cmd.op = OP_NOP;
                end else if (is_digit) begin
                  cmd.op = OP_ARG_DIGIT;
                end else if (byte_q == ChSemi) begin
                  cmd.op = OP_ARG_NEXT;
                end else if (is_final) begin
                  parse_state_next = P_GROUND;
                  case (byte_q)
                    FinIch: begin
                      ich_left_next = stat.ich_count;
                      state_next    = S_ICH;
                    end
                    FinCuu: cmd.op = OP_UP;
                    FinCud, FinVpr: cmd.op = OP_DOWN;
                    FinCuf, FinHpr: cmd.op = OP_RIGHT;
                    FinCub: cmd.op = OP_LEFT;
                    FinCnl: cmd.op = OP_NEXT_LINE;
                    FinCpl: cmd.op = OP_PREV_LINE;
                    FinSgr: begin
                      sgr_i_next = 5'd0;
                      state_next = S_SGR;
                    end
                    default: ;
                  endcase
                end else begin
                  parse_state_next = (byte_q == ChEsc) ? P_ESC : P_GROUND;
                end
              end
              default: begin
                parse_state_next = P_GROUND;
                if (byte_q == ChEsc) parse_state_next = P_ESC;
                else if (byte_q == ChTab) cmd.op = OP_TAB;
                else if (byte_q == ChCr) cmd.op = OP_CR;
                else if (byte_q >= ChSpace && byte_q <= ChTilde) cmd.op = OP_DRAW;
              end
            endcase
          end
        end
      end
      S_ICH: begin
        if (stat.out_free) begin
          cmd.op        = OP_DRAW;
          cmd.glyph     = ChSpace;
          cmd.last      = (ich_left == 7'd1);
          ich_left_next = ich_left - 7'd1;
          if (ich_left == 7'd1) state_next = S_IDLE;
        end
      end
      S_SGR: begin
        if (sgr_i >= stat.nargs) begin
          state_next = S_IDLE;
        end else if (stat.sgr_code == SgrFgExt || stat.sgr_code == SgrBgExt) begin
          sgr_i_next = sgr_i + 5'd1;
          if (sgr_i + 5'd1 < stat.nargs) state_next = S_SGR_EXT;
        end else begin
          cmd.op     = OP_SGR;
          sgr_i_next = sgr_i + 5'd1;
        end
      end
      S_SGR_EXT: begin
        state_next = S_SGR;
        if (stat.sgr_code == SgrIdx) sgr_i_next = sgr_i + 5'd2;
        else if (stat.sgr_code == SgrRgb) sgr_i_next = sgr_i + 5'd4;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      parse_state <= P_GROUND;
      ich_left    <= 7'd0;
      sgr_i       <= 5'd0;
    end else begin
      state       <= state_next;
      parse_state <= parse_state_next;
      ich_left    <= ich_left_next;
      sgr_i       <= sgr_i_next;
    end
    if (state == S_IDLE && in_valid) byte_q <= data_byte;
  end

  a_draw_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DRAW || cmd.op == OP_LF || cmd.op == OP_TAB) |-> stat.out_free)
    else $error("result issued into a full output register");
  a_ich_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_ICH) |-> (ich_left != 7'd0))
    else $error("blank insertion with no blanks left");
  a_ext_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SGR_EXT) |-> (sgr_i < stat.nargs))
    else $error("extended colour operand read past the argument list");
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid) |=> (state == S_DECODE))
    else $error("accepted word not decoded");

endmodule
